// ===== rtl/sil_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types, codes and defaults for the sorted insertion list unit.
// ----------------------------------------------------------------------------
package sil_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int WORD_W       = 32;
  localparam int STATUS_W     = 2;

  typedef logic signed [WORD_W-1:0] sil_word_t;
  typedef logic [STATUS_W-1:0]      sil_status_t;

  // Input operation codes
  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_READOUT = 1'b1;

  // Result status codes
  localparam sil_status_t STATUS_OK    = 2'd0;
  localparam sil_status_t STATUS_FULL  = 2'd1;
  localparam sil_status_t STATUS_EMPTY = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic        insert;         // shift larger entries up and place the new value
    logic        snap;           // copy the store into the readout shift line
    logic        emit;           // load the head of the readout line into the output
    logic        single;         // load a one-shot result with zero value
    sil_status_t single_status;
  } sil_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;
    logic empty;
    logic rd_last;               // next emit is the final readout result
    logic out_busy;              // output register holds a result that is not taken
  } sil_stat_t;

endpackage : sil_pkg
`default_nettype wire

// ===== rtl/sil_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sil_if
// Valid/ready channels of the sorted insertion list unit: the input item
// channel and the result channel.
// ----------------------------------------------------------------------------
interface sil_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [31:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface : sil_in_if

interface sil_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_value;
  logic [1:0]         status;
  logic               last;

  modport source (output valid, output out_value, output status, output last,
                  input ready);
  modport sink   (input valid, input out_value, input status, input last,
                  output ready);
endinterface : sil_out_if
`default_nettype wire

// ===== rtl/sil_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sil_ctrl
// Controller: accepts input transactions, decodes them into datapath
// commands and sequences the readout burst.
// ----------------------------------------------------------------------------
module sil_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_op,
  output logic               in_ready,
  input  sil_pkg::sil_stat_t stat,
  output sil_pkg::sil_cmd_t  cmd
);
  import sil_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic state_r;
  logic state_nxt;
  logic accept;

  assign in_ready = (state_r == ST_IDLE) && !stat.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd               = '0;
    cmd.single_status = STATUS_OK;
    state_nxt         = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_INSERT) begin
            cmd.insert        = !stat.full;
            cmd.single        = 1'b1;
            cmd.single_status = stat.full ? STATUS_FULL : STATUS_OK;
          end else if (stat.empty) begin
            cmd.single        = 1'b1;
            cmd.single_status = STATUS_EMPTY;
          end else begin
            cmd.snap  = 1'b1;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        // advance one value whenever the output register frees up
        if (!stat.out_busy) begin
          cmd.emit = 1'b1;
          if (stat.rd_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule : sil_ctrl
`default_nettype wire

// ===== rtl/sil_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sil_dp
// Datapath: a row of sorted cells with parallel compare-and-shift insert,
// a readout shift line, the entry count and the result output register.
// ----------------------------------------------------------------------------
module sil_dp #(
  parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sil_pkg::sil_word_t in_value,
  input  sil_pkg::sil_cmd_t  cmd,
  output sil_pkg::sil_stat_t stat,
  input  logic               out_ready,
  output logic               out_valid,
  output sil_pkg::sil_word_t out_value,
  output sil_pkg::sil_status_t out_status,
  output logic               out_last
);
  import sil_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  sil_word_t           cells_r [CAPACITY];
  sil_word_t           shadow_r[CAPACITY];
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [CW-1:0]       rd_cnt_r;
  logic [CW-1:0]       rd_cnt_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  sil_word_t           out_value_r;
  sil_status_t         out_status_r;
  logic                out_last_r;
  logic [CAPACITY-1:0] take;

  // A cell takes new data if it holds a valid larger value or is the first free slot
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      take[i] = ((CW'(i) < count_r) && (cells_r[i] > in_value)) || (CW'(i) == count_r);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    localparam int PREV = (g > 0) ? g - 1 : 0;

    always_ff @(posedge clk) begin
      if (cmd.insert && take[g]) begin
        if (g == 0) begin
          cells_r[g] <= in_value;
        end else begin
          cells_r[g] <= take[PREV] ? cells_r[PREV] : in_value;
        end
      end
      if (cmd.snap) begin
        shadow_r[g] <= cells_r[g];
      end else if (cmd.emit) begin
        if (g < CAPACITY - 1) begin
          shadow_r[g] <= shadow_r[(g < CAPACITY - 1) ? g + 1 : g];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.insert) begin
      count_nxt = count_r + CW'(1);
    end
    rd_cnt_nxt = rd_cnt_r;
    if (cmd.snap) begin
      rd_cnt_nxt = count_r;
    end else if (cmd.emit) begin
      rd_cnt_nxt = rd_cnt_r - CW'(1);
    end
    out_valid_nxt = out_valid_r;
    if (cmd.single || cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.single) begin
      out_value_r  <= '0;
      out_status_r <= cmd.single_status;
      out_last_r   <= 1'b1;
    end else if (cmd.emit) begin
      out_value_r  <= shadow_r[0];
      out_status_r <= STATUS_OK;
      out_last_r   <= (rd_cnt_r == CW'(1));
    end
  end

  assign stat.full     = (count_r == CW'(CAPACITY));
  assign stat.empty    = (count_r == '0);
  assign stat.rd_last  = (rd_cnt_r == CW'(1));
  assign stat.out_busy = out_valid_r && !out_ready;

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |=> (count_r == $past(count_r) + CW'(1)))
    else $error("insert did not advance the entry count");

  a_emit_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (rd_cnt_r != '0))
    else $error("readout emit with no values left");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.single || cmd.emit) |-> !(out_valid_r && !out_ready))
    else $error("output register overwritten while stalled");

  a_insert_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> !stat.full)
    else $error("insert into a full store");
`endif

endmodule : sil_dp
`default_nettype wire

// ===== rtl/sorted_insertion_list_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_insertion_list_unit
// Bounded store of signed 32-bit values kept in ascending order, with
// stable insert and in-order readout.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                      Transaction
//  in_ch     in   op, value                    one insert or readout request
//  out_ch    out  out_value, status, last      one result
//
//  Insert (ok or full) and readout of an empty store: one result per item. Readout
//  of n values: the store is first copied into the readout shift line, then one
//  result per cycle while out_ch does not stall; the next item is taken once the
//  last result is loaded and out_ch takes it.
//  A stall on out_ch holds the output register and holds off in_ch.
//  Reset is synchronous on rst_n and empties the store.
// ----------------------------------------------------------------------------
module sorted_insertion_list_unit #(
  parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
  input logic       clk,
  input logic       rst_n,
  sil_in_if.sink    in_ch,
  sil_out_if.source out_ch
);
  import sil_pkg::*;

  sil_cmd_t  cmd;
  sil_stat_t stat;

  sil_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_op    (in_ch.op),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sil_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_value   (in_ch.value),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_value  (out_ch.out_value),
    .out_status (out_ch.status),
    .out_last   (out_ch.last)
  );

endmodule : sorted_insertion_list_unit
`default_nettype wire
